// ===== rtl/i2cm_pkg.sv =====
`timescale 1ns / 1ps

package i2cm_pkg;

  // Command codes carried in the kind field
  localparam logic [2:0] KIND_NONE  = 3'd0;
  localparam logic [2:0] KIND_START = 3'd1;
  localparam logic [2:0] KIND_STOP  = 3'd2;
  localparam logic [2:0] KIND_SEND  = 3'd3;
  localparam logic [2:0] KIND_WACK  = 3'd4;
  localparam logic [2:0] KIND_READ  = 3'd5;

  // Configuration register indexes
  localparam logic CFG_TICKS_PER_US = 1'b0;
  localparam logic CFG_ACK_TIMEOUT  = 1'b1;

  localparam logic [7:0]  TICKS_PER_US_RST = 8'd1;
  localparam logic [15:0] ACK_TIMEOUT_RST  = 16'd1000;

  localparam int unsigned DELAY_W = 10;
  localparam int unsigned BITS_PER_BYTE = 8;

  typedef enum logic [1:0] {
    STAT_OK      = 2'd0,
    STAT_TIMEOUT = 2'd1,
    STAT_NACK    = 2'd2
  } stat_t;

  typedef enum logic [14:0] {
    PH_IDLE    = 15'b000000000000001,
    PH_ST_A    = 15'b000000000000010,
    PH_ST_B    = 15'b000000000000100,
    PH_SP_A    = 15'b000000000001000,
    PH_TX_HI   = 15'b000000000010000,
    PH_TX_NEXT = 15'b000000000100000,
    PH_AK_POLL = 15'b000000001000000,
    PH_AK_CHK  = 15'b000000010000000,
    PH_AK_END  = 15'b000000100000000,
    PH_RD_HI   = 15'b000001000000000,
    PH_RD_NEXT = 15'b000010000000000,
    PH_RD_ACK  = 15'b000100000000000,
    PH_RD_REL  = 15'b001000000000000,
    PH_RD_END  = 15'b010000000000000,
    PH_RD_LOW  = 15'b100000000000000
  } phase_t;

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] tx_byte;
    logic       send_ack;
    logic       sda_in;
  } in_item_t;

  typedef struct packed {
    logic       scl_out;
    logic       sda_out;
    logic       busy_res;
    logic       done_res;
    logic [1:0] status;
    logic [7:0] rx_byte;
  } out_item_t;

endpackage

// ===== rtl/i2cm_seq.sv =====
`timescale 1ns / 1ps

module i2cm_seq (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               step_en,
  input  i2cm_pkg::in_item_t item,
  input  logic [7:0]         ticks_per_us,
  input  logic [15:0]        ack_timeout,
  output i2cm_pkg::out_item_t res
);

  i2cm_pkg::phase_t              phase_r, phase_nxt;
  logic [i2cm_pkg::DELAY_W-1:0]  delay_r, delay_nxt;
  logic [3:0]                    bit_idx_r, bit_idx_nxt;
  logic [7:0]                    shift_r, shift_nxt;
  logic [15:0]                   tmo_r, tmo_nxt;
  logic                          ack_sel_r, ack_sel_nxt;
  logic                          scl_r, scl_nxt;
  logic                          sda_r, sda_nxt;
  i2cm_pkg::stat_t               stat_r, stat_nxt;
  logic [7:0]                    rx_r, rx_nxt;
  logic                          done;
  logic [i2cm_pkg::DELAY_W-1:0]  dly_1us, dly_2us;
  logic [3:0]                    bit_inc;

  assign dly_1us = {2'b00, ticks_per_us};
  assign dly_2us = {1'b0, ticks_per_us, 1'b0};
  assign bit_inc = bit_idx_r + 4'd1;

  always_comb begin
    phase_nxt   = phase_r;
    delay_nxt   = delay_r;
    bit_idx_nxt = bit_idx_r;
    shift_nxt   = shift_r;
    tmo_nxt     = tmo_r;
    ack_sel_nxt = ack_sel_r;
    scl_nxt     = scl_r;
    sda_nxt     = sda_r;
    stat_nxt    = stat_r;
    rx_nxt      = rx_r;
    done        = 1'b0;

    if (phase_r == i2cm_pkg::PH_IDLE) begin
      unique case (item.kind)
        i2cm_pkg::KIND_START: begin
          scl_nxt = 1'b1; sda_nxt = 1'b1;
          delay_nxt = dly_2us; phase_nxt = i2cm_pkg::PH_ST_A;
        end
        i2cm_pkg::KIND_STOP: begin
          scl_nxt = 1'b1; sda_nxt = 1'b0;
          delay_nxt = dly_2us; phase_nxt = i2cm_pkg::PH_SP_A;
        end
        i2cm_pkg::KIND_SEND: begin
          shift_nxt = item.tx_byte; bit_idx_nxt = 4'd0;
          scl_nxt = 1'b0; sda_nxt = item.tx_byte[7];
          delay_nxt = dly_1us; phase_nxt = i2cm_pkg::PH_TX_HI;
        end
        i2cm_pkg::KIND_WACK: begin
          scl_nxt = 1'b1;
          if (!item.sda_in) begin
            tmo_nxt = ack_timeout;
            delay_nxt = dly_2us; phase_nxt = i2cm_pkg::PH_AK_CHK;
          end else begin
            tmo_nxt = ack_timeout - 16'd1;
            delay_nxt = dly_1us; phase_nxt = i2cm_pkg::PH_AK_POLL;
          end
        end
        i2cm_pkg::KIND_READ: begin
          shift_nxt = 8'd0; bit_idx_nxt = 4'd0; ack_sel_nxt = item.send_ack;
          sda_nxt = 1'b1; scl_nxt = 1'b0;
          delay_nxt = dly_2us; phase_nxt = i2cm_pkg::PH_RD_HI;
        end
        default: ;
      endcase
    end else if (delay_r > 10'd1) begin
      delay_nxt = delay_r - 10'd1;
    end else begin
      delay_nxt = '0;
      unique case (phase_r)
        i2cm_pkg::PH_ST_A: begin
          sda_nxt = 1'b0; delay_nxt = dly_2us; phase_nxt = i2cm_pkg::PH_ST_B;
        end
        i2cm_pkg::PH_ST_B: begin
          scl_nxt = 1'b0; phase_nxt = i2cm_pkg::PH_IDLE; done = 1'b1;
        end
        i2cm_pkg::PH_SP_A: begin
          sda_nxt = 1'b1; phase_nxt = i2cm_pkg::PH_IDLE; done = 1'b1;
        end
        i2cm_pkg::PH_TX_HI: begin
          scl_nxt = 1'b1; shift_nxt = {shift_r[6:0], 1'b0};
          delay_nxt = dly_2us; phase_nxt = i2cm_pkg::PH_TX_NEXT;
        end
        i2cm_pkg::PH_TX_NEXT: begin
          bit_idx_nxt = bit_inc;
          if (bit_inc < 4'(i2cm_pkg::BITS_PER_BYTE)) begin
            scl_nxt = 1'b0; sda_nxt = shift_r[7];
            delay_nxt = dly_1us; phase_nxt = i2cm_pkg::PH_TX_HI;
          end else begin
            scl_nxt = 1'b0; sda_nxt = 1'b1;
            phase_nxt = i2cm_pkg::PH_IDLE; done = 1'b1;
          end
        end
        i2cm_pkg::PH_AK_POLL: begin
          if (tmo_r == 16'd0) begin
            stat_nxt = i2cm_pkg::STAT_TIMEOUT; phase_nxt = i2cm_pkg::PH_IDLE; done = 1'b1;
          end else if (!item.sda_in) begin
            scl_nxt = 1'b1; delay_nxt = dly_2us; phase_nxt = i2cm_pkg::PH_AK_CHK;
          end else begin
            tmo_nxt = tmo_r - 16'd1; delay_nxt = dly_1us;
          end
        end
        i2cm_pkg::PH_AK_CHK: begin
          if (item.sda_in) begin
            stat_nxt = i2cm_pkg::STAT_NACK; phase_nxt = i2cm_pkg::PH_IDLE; done = 1'b1;
          end else begin
            scl_nxt = 1'b0; delay_nxt = dly_2us; phase_nxt = i2cm_pkg::PH_AK_END;
          end
        end
        i2cm_pkg::PH_AK_END: begin
          stat_nxt = i2cm_pkg::STAT_OK; phase_nxt = i2cm_pkg::PH_IDLE; done = 1'b1;
        end
        i2cm_pkg::PH_RD_HI: begin
          scl_nxt = 1'b1; shift_nxt = {shift_r[6:0], item.sda_in};
          delay_nxt = dly_2us; phase_nxt = i2cm_pkg::PH_RD_NEXT;
        end
        i2cm_pkg::PH_RD_NEXT: begin
          bit_idx_nxt = bit_inc; scl_nxt = 1'b0; delay_nxt = dly_2us;
          phase_nxt = (bit_inc < 4'(i2cm_pkg::BITS_PER_BYTE)) ? i2cm_pkg::PH_RD_HI
                                                             : i2cm_pkg::PH_RD_ACK;
        end
        i2cm_pkg::PH_RD_ACK: begin
          sda_nxt = ~ack_sel_r; scl_nxt = 1'b1;
          delay_nxt = dly_2us; phase_nxt = i2cm_pkg::PH_RD_REL;
        end
        i2cm_pkg::PH_RD_REL: begin
          scl_nxt = 1'b0; sda_nxt = 1'b1;
          delay_nxt = dly_2us; phase_nxt = i2cm_pkg::PH_RD_END;
        end
        i2cm_pkg::PH_RD_END: begin
          rx_nxt = shift_r; phase_nxt = i2cm_pkg::PH_IDLE; done = 1'b1;
        end
        default: phase_nxt = i2cm_pkg::PH_IDLE;
      endcase
    end
  end

  always_comb begin
    res.scl_out  = scl_nxt;
    res.sda_out  = sda_nxt;
    res.busy_res = (phase_nxt != i2cm_pkg::PH_IDLE);
    res.done_res = done;
    res.status   = stat_nxt;
    res.rx_byte  = rx_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= i2cm_pkg::PH_IDLE;
      delay_r   <= '0;
      bit_idx_r <= '0;
      shift_r   <= '0;
      tmo_r     <= '0;
      ack_sel_r <= 1'b0;
      scl_r     <= 1'b1;
      sda_r     <= 1'b1;
      stat_r    <= i2cm_pkg::STAT_OK;
      rx_r      <= '0;
    end else if (step_en) begin
      phase_r   <= phase_nxt;
      delay_r   <= delay_nxt;
      bit_idx_r <= bit_idx_nxt;
      shift_r   <= shift_nxt;
      tmo_r     <= tmo_nxt;
      ack_sel_r <= ack_sel_nxt;
      scl_r     <= scl_nxt;
      sda_r     <= sda_nxt;
      stat_r    <= stat_nxt;
      rx_r      <= rx_nxt;
    end
  end

endmodule

// ===== rtl/i2c_master_bit_sequencer_top.sv =====
`timescale 1ns / 1ps
// I2C master bit sequencer: one request per bus tick drives the SCL/SDA levels.
// Request channel (in_valid / in_stall / in_data): each request is one tick and
//   carries the sampled SDA level plus a command (start, stop, send byte, wait
//   ack, read byte) that is taken only while no command is in progress.
// Result channel (out_valid / out_stall / out_data): exactly one result per
//   request, in order: SCL/SDA drive, busy, a one-tick done pulse, the last
//   ack status and the last received byte.
// Config port (cfg_we / cfg_index / cfg_wdata): index 0 ticks per microsecond,
//   index 1 ack timeout in microseconds; write only while idle.
// Path: a request is held in the request register, then its result in the
//   result register, from which it is taken. Throughput is one request per
//   cycle while out_stall does not hold the result register; the only loop
//   is the sequencer state update.
// Stall: when the result register is held by out_stall, one further request is
//   taken into the request register; after that in_stall rises until the
//   result is taken.
// Reset (synchronous, rst_n low): drop both registers, return the sequencer to
//   idle with SCL and SDA released, and restore the register defaults.
module i2c_master_bit_sequencer_top (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  i2cm_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output i2cm_pkg::out_item_t out_data,
  input  logic                cfg_we,
  input  logic                cfg_index,
  input  logic [15:0]         cfg_wdata
);

  i2cm_pkg::in_item_t  req_r;
  logic                req_vld_r, req_vld_nxt;
  i2cm_pkg::out_item_t res_r;
  logic                res_vld_r, res_vld_nxt;
  i2cm_pkg::out_item_t step_res;
  logic [7:0]          tpu_r;
  logic [15:0]         ack_tmo_r;
  logic                advance;
  logic                step;
  logic                take;

  // The result register is free when empty or being taken this cycle
  assign advance  = !res_vld_r || !out_stall;
  assign step     = req_vld_r && advance;
  assign in_stall = req_vld_r && !advance;
  assign take     = in_valid && !in_stall;

  assign req_vld_nxt = take || (req_vld_r && !advance);
  assign res_vld_nxt = step || (res_vld_r && out_stall);

  i2cm_seq u_seq (
    .clk          (clk),
    .rst_n        (rst_n),
    .step_en      (step),
    .item         (req_r),
    .ticks_per_us (tpu_r),
    .ack_timeout  (ack_tmo_r),
    .res          (step_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_vld_r <= 1'b0;
      res_vld_r <= 1'b0;
      tpu_r     <= i2cm_pkg::TICKS_PER_US_RST;
      ack_tmo_r <= i2cm_pkg::ACK_TIMEOUT_RST;
    end else begin
      req_vld_r <= req_vld_nxt;
      res_vld_r <= res_vld_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          i2cm_pkg::CFG_TICKS_PER_US: tpu_r     <= cfg_wdata[7:0];
          i2cm_pkg::CFG_ACK_TIMEOUT:  ack_tmo_r <= cfg_wdata;
          default: ;
        endcase
      end
    end
  end

  // Payload registers: load the request on take, the result on each step
  always_ff @(posedge clk) begin
    if (take) begin
      req_r <= in_data;
    end
    if (step) begin
      res_r <= step_res;
    end
  end

  assign out_valid = res_vld_r;
  assign out_data  = res_r;

endmodule

// ===== rtl/i2cm_chk.sv =====
`timescale 1ns / 1ps

module i2cm_chk (
  input logic                clk,
  input logic                rst_n,
  input logic                in_stall,
  input logic                out_valid,
  input logic                out_stall,
  input i2cm_pkg::out_item_t out_data
);

  // A held result keeps its value
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // Requests are only refused while a result is held back
  a_stall_src: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("request stalled without result back-pressure");

  // A completing command leaves the sequencer idle
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.done_res |-> !out_data.busy_res)
    else $error("done pulse while still busy");

  // Nothing is delivered and no request is refused in the cycle after reset
  a_rst_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("channel not empty after reset");

endmodule

bind i2c_master_bit_sequencer_top i2cm_chk u_i2cm_chk (.*);
